/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the matrix transform RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define M4VT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Expression must never be true outside reset
`define M4VT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

/* hw/rtl/m4vt_pkg.sv */
// Shared types and constants for the 4x4 matrix vector transform unit.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package m4vt_pkg;

	localparam int unsigned LANES      = 4;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned MODE_W     = 3;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned IN_DATA_W  = 168;
	localparam int unsigned OUT_DATA_W = 128;

	// input tdata field offsets
	localparam int unsigned IDX_LSB  = 0;
	localparam int unsigned ELEM_LSB = 4;
	localparam int unsigned VEC_LSB  = 36;

	typedef enum logic [MODE_W-1:0] {
		MODE_WR_CUR   = 3'd0,
		MODE_WR_OP    = 3'd1,
		MODE_MUL      = 3'd2,
		MODE_XFORM_V  = 3'd3,
		MODE_XFORM_PT = 3'd4,
		MODE_TRANS    = 3'd5,
		MODE_IDENT    = 3'd6
	} mode_t;

	// sweep kinds run by the datapath
	typedef enum logic [1:0] {
		OP_XFORM = 2'd0,
		OP_MUL   = 2'd1,
		OP_TRANS = 2'd2
	} op_t;

	typedef struct packed {
		logic       load;
		logic       wr_cur;
		logic       wr_op;
		logic       set_ident;
		logic       flip;
		logic       issue;
		op_t        op;
		logic [3:0] cnt;
		logic       first;
		logic       last;
		logic       point;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic out_full;
	} stat_t;

endpackage

`default_nettype wire

/* hw/rtl/matrix4_vertex_transform_unit.sv */
// Top level of the 4x4 column-major matrix vector transform unit.
// Depends on m4vt_pkg, m4vt_ctrl and m4vt_datapath.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready. s_tuser carries the mode: element
//   write to the current or operand matrix, current = current * operand,
//   vector or point transform, transpose, identity. s_tdata carries index,
//   element value and the x, y, z, w vector components.
//   Only the two transform modes produce an output word on m_tvalid/m_tready,
//   holding x, y, z, w saturated in Q16.16 (w is zero for a point).
//   One word is processed at a time; s_tready is high only while idle.
//   A transform runs 4 passes of the four lane multipliers through a read,
//   multiply, accumulate and saturate pipe; a matrix multiply runs 16 passes
//   through the same lanes.
//   A transform's output word is registered once its last pass has been
//   accumulated and saturated.
//   The output register frees the input side: a new word is accepted while a
//   result waits. A transform that finds the output word still held waits for
//   it to be taken before it starts, so a stalled receiver stalls the input.
//   After reset both matrices read as identity and no word is pending.
`default_nettype none

module matrix4_vertex_transform_unit import m4vt_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// index[3:0], elem_value[35:4], in_x[67:36], in_y[99:68], in_z[131:100],
	// in_w[163:132], zero pad[167:164]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// mode[2:0]
	input  wire logic [MODE_W-1:0]     s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	cmd_t  cmd;
	stat_t stat;

	m4vt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	m4vt_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

/* hw/rtl/m4vt_ctrl.sv */
// Controller for the matrix transform unit: decodes the mode and sequences sweeps.
// Depends on m4vt_pkg; drives the datapath through cmd_t, watches stat_t.
`default_nettype none

module m4vt_ctrl import m4vt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [MODE_W-1:0] s_tuser,
	input  wire stat_t             stat,
	output cmd_t                   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ISSUE,
		ST_DRAIN
	} st_t;

	st_t        state_q;
	mode_t      mode_q;
	op_t        op_q;
	logic       point_q;
	logic [3:0] cnt_q;
	logic       accept;
	logic       issue_end;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	// multiply walks 16 column/term pairs, the other sweeps four
	assign issue_end = (op_q == OP_MUL) ? (cnt_q == 4'd15) : (cnt_q[1:0] == 2'd3);

	// state and sweep registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_WR_CUR;
			op_q    <= OP_XFORM;
			point_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q  <= mode_t'(s_tuser);
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					unique case (mode_q)
						MODE_MUL: begin
							op_q    <= OP_MUL;
							cnt_q   <= '0;
							state_q <= ST_ISSUE;
						end
						MODE_TRANS: begin
							op_q    <= OP_TRANS;
							cnt_q   <= '0;
							state_q <= ST_ISSUE;
						end
						MODE_XFORM_V, MODE_XFORM_PT: begin
							// hold until the output word is free
							if (!stat.out_full) begin
								op_q    <= OP_XFORM;
								point_q <= (mode_q == MODE_XFORM_PT);
								cnt_q   <= '0;
								state_q <= ST_ISSUE;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + 4'd1;
					if (issue_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.wr_cur    = (state_q == ST_DECODE) && (mode_q == MODE_WR_CUR);
		cmd.wr_op     = (state_q == ST_DECODE) && (mode_q == MODE_WR_OP);
		cmd.set_ident = (state_q == ST_DECODE) && (mode_q == MODE_IDENT);
		cmd.issue     = (state_q == ST_ISSUE);
		cmd.op        = op_q;
		cmd.cnt       = cnt_q;
		cmd.first     = (cnt_q[1:0] == 2'd0);
		cmd.last      = (cnt_q[1:0] == 2'd3);
		cmd.point     = point_q;
		cmd.flip      = (state_q == ST_DRAIN) && !stat.busy && (op_q != OP_XFORM);
	end

endmodule

`default_nettype wire

/* hw/rtl/m4vt_datapath.sv */
// Datapath: banked matrix storage, four multiply-accumulate lanes, output register.
// Depends on m4vt_pkg and assert_macros.svh; driven by m4vt_ctrl through cmd_t.
`default_nettype none
`include "assert_macros.svh"

module m4vt_datapath import m4vt_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire cmd_t                  cmd,
	output stat_t                      stat,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	typedef logic signed [WORD_W-1:0] word_t;

	localparam int unsigned ACC_W = 66 - FRAC_BITS;
	localparam word_t FX_ONE  = WORD_W'(64'sd1 <<< FRAC_BITS);
	localparam word_t SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// latched item
	logic [IDX_W-1:0] idx_q;
	word_t            elem_q;
	word_t            vec_q [LANES];

	// current matrix: one bank per row, two pages of four columns
	word_t      cur_mem [LANES][8];
	logic [7:0] cur_vld_q [LANES];
	logic       page_q;
	word_t      op_mem [16];
	logic [15:0] op_vld_q;

	// issue side
	logic [1:0] iss_k;
	logic [1:0] rcol [LANES];
	word_t      vec_sel;

	// stage 1: read data
	logic             vld_s1;
	op_t              op_s1;
	logic             first_s1, last_s1, pnt_s1;
	logic [1:0]       col_s1, k_s1;
	word_t            crd_s1 [LANES];
	logic [LANES-1:0] cvld_s1;
	logic [1:0]       ccol_s1 [LANES];
	word_t            ord_s1;
	logic             ovld_s1, odiag_s1;
	word_t            vec_s1;
	word_t            curv [LANES];
	word_t            scalar;
	logic             tr_wr;

	// stage 2: products
	logic               vld_s2;
	op_t                op_s2;
	logic               first_s2, last_s2, pnt_s2;
	logic [1:0]         col_s2;
	logic signed [63:0] prod_s2 [LANES];
	logic signed [63:0] shp [LANES];
	logic signed [ACC_W-1:0] term [LANES];

	// stage 3: accumulators
	logic                    done_s3;
	op_t                     op_s3;
	logic                    pnt_s3;
	logic [1:0]              col_s3;
	logic signed [ACC_W-1:0] acc_s3 [LANES];
	word_t                   sat [LANES];
	logic                    mul_wr, out_ld;

	// write port per bank
	logic       we [LANES];
	logic [2:0] wa [LANES];
	word_t      wd [LANES];

	// output word
	logic  out_vld_q;
	word_t out_q [LANES];
	logic  busy;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q  <= s_tdata[IDX_LSB +: IDX_W];
			elem_q <= s_tdata[ELEM_LSB +: WORD_W];
			for (int l = 0; l < LANES; l++) begin
				vec_q[l] <= s_tdata[VEC_LSB + l*WORD_W +: WORD_W];
			end
		end
	end

	// read addresses; transpose reads a rotated diagonal
	assign iss_k = cmd.cnt[1:0];
	always_comb begin
		for (int b = 0; b < LANES; b++) begin
			rcol[b] = (cmd.op == OP_TRANS) ? 2'(2'(b) + iss_k) : iss_k;
		end
		vec_sel = (cmd.point && iss_k == 2'd3) ? FX_ONE : vec_q[iss_k];
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			for (int b = 0; b < LANES; b++) begin
				crd_s1[b]  <= cur_mem[b][{page_q, rcol[b]}];
				cvld_s1[b] <= cur_vld_q[b][{page_q, rcol[b]}];
				ccol_s1[b] <= rcol[b];
			end
			ord_s1   <= op_mem[cmd.cnt];
			ovld_s1  <= op_vld_q[cmd.cnt];
			odiag_s1 <= (cmd.cnt[3:2] == cmd.cnt[1:0]);
			vec_s1   <= vec_sel;
			op_s1    <= cmd.op;
			first_s1 <= cmd.first;
			last_s1  <= cmd.last;
			pnt_s1   <= cmd.point;
			col_s1   <= cmd.cnt[3:2];
			k_s1     <= iss_k;
		end
	end

	// unwritten entries read as identity
	always_comb begin
		for (int b = 0; b < LANES; b++) begin
			curv[b] = cvld_s1[b] ? crd_s1[b] : ((ccol_s1[b] == 2'(b)) ? FX_ONE : '0);
		end
		if (op_s1 == OP_MUL) begin
			scalar = ovld_s1 ? ord_s1 : (odiag_s1 ? FX_ONE : '0);
		end else begin
			scalar = vec_s1;
		end
	end

	assign tr_wr = vld_s1 && (op_s1 == OP_TRANS);

	// stage 2: four multipliers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1 && (op_s1 != OP_TRANS);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < LANES; r++) begin
			prod_s2[r] <= 64'(curv[r]) * 64'(scalar);
		end
		op_s2    <= op_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		pnt_s2   <= pnt_s1;
		col_s2   <= col_s1;
	end

	// floor shift of each product
	always_comb begin
		for (int r = 0; r < LANES; r++) begin
			shp[r]  = prod_s2[r] >>> FRAC_BITS;
			term[r] = $signed(shp[r][ACC_W-1:0]);
		end
	end

	// stage 3: accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= vld_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			for (int r = 0; r < LANES; r++) begin
				acc_s3[r] <= first_s2 ? term[r] : acc_s3[r] + term[r];
			end
			op_s3  <= op_s2;
			pnt_s3 <= pnt_s2;
			col_s3 <= col_s2;
		end
	end

	// saturate to 32 bits
	always_comb begin
		for (int r = 0; r < LANES; r++) begin
			if ((&acc_s3[r][ACC_W-1:WORD_W-1]) || !(|acc_s3[r][ACC_W-1:WORD_W-1])) begin
				sat[r] = acc_s3[r][WORD_W-1:0];
			end else if (acc_s3[r][ACC_W-1]) begin
				sat[r] = SAT_MIN;
			end else begin
				sat[r] = SAT_MAX;
			end
		end
	end

	assign mul_wr = done_s3 && (op_s3 == OP_MUL);
	assign out_ld = done_s3 && (op_s3 == OP_XFORM);

	// bank write select; sweeps write the inactive page
	always_comb begin
		for (int b = 0; b < LANES; b++) begin
			we[b] = 1'b0;
			wa[b] = {page_q, idx_q[3:2]};
			wd[b] = elem_q;
			if (cmd.wr_cur && idx_q[1:0] == 2'(b)) begin
				we[b] = 1'b1;
			end else if (tr_wr) begin
				we[b] = 1'b1;
				wa[b] = {~page_q, 2'(2'(b) - k_s1)};
				wd[b] = curv[2'(2'(b) - k_s1)];
			end else if (mul_wr) begin
				we[b] = 1'b1;
				wa[b] = {~page_q, col_s3};
				wd[b] = sat[b];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < LANES; b++) begin
			if (we[b]) begin
				cur_mem[b][wa[b]] <= wd[b];
			end
		end
		if (cmd.wr_op) begin
			op_mem[idx_q] <= elem_q;
		end
	end

	// valid bits and page select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < LANES; b++) begin
				cur_vld_q[b] <= '0;
			end
			op_vld_q <= '0;
			page_q   <= 1'b0;
		end else begin
			if (cmd.flip) begin
				page_q <= ~page_q;
			end
			for (int b = 0; b < LANES; b++) begin
				if (cmd.set_ident) begin
					for (int c = 0; c < LANES; c++) begin
						cur_vld_q[b][{page_q, 2'(c)}] <= 1'b0;
					end
				end else if (we[b]) begin
					cur_vld_q[b][wa[b]] <= 1'b1;
				end
			end
			if (cmd.wr_op) begin
				op_vld_q[idx_q] <= 1'b1;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_ld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_q[0] <= sat[0];
			out_q[1] <= sat[1];
			out_q[2] <= sat[2];
			out_q[3] <= pnt_s3 ? '0 : sat[3];
		end
	end

	assign m_tvalid      = out_vld_q;
	assign m_tdata       = {out_q[3], out_q[2], out_q[1], out_q[0]};
	assign busy          = vld_s1 || vld_s2 || done_s3;
	assign stat.busy     = busy;
	assign stat.out_full = out_vld_q;

	`M4VT_ASSERT(a_out_free, (done_s3 && op_s3 == OP_XFORM) |-> !out_vld_q, "transform result would overwrite a pending word")
	`M4VT_NEVER(a_ident_busy, cmd.set_ident && busy, "identity reset during a sweep")
	`M4VT_NEVER(a_flip_busy, cmd.flip && busy, "page flip before sweep writes finished")
	`M4VT_ASSERT(a_done_order, done_s3 |-> $past(vld_s2), "accumulator done without a product")

endmodule

`default_nettype wire
